// ----- rtl/core/bb3_pkg.sv -----
package bb3_pkg;

    localparam int CHAN_W     = 16;
    localparam int COORD_W    = 10;
    localparam int CFG_W      = 11;
    localparam int PIX_W      = 3 * CHAN_W;
    localparam int LINE_W     = 2 * PIX_W;
    localparam int COL_SUM_W  = CHAN_W + 2;
    localparam int SUM_W      = CHAN_W + 4;
    localparam int RECIP_W    = 25;
    localparam int PROD_W     = SUM_W + RECIP_W;
    localparam int RECIP_SH   = 24;
    localparam int NUM_JOBS   = 4;
    localparam int CFG_RESET_SIDE = 1024;

    // reciprocals scaled by 2^24, rounded up; exact for sums below 2^20
    localparam logic [RECIP_W-1:0] RECIP_DIV1 = 25'd16777216;
    localparam logic [RECIP_W-1:0] RECIP_DIV2 = 25'd8388608;
    localparam logic [RECIP_W-1:0] RECIP_DIV3 = 25'd5592406;
    localparam logic [RECIP_W-1:0] RECIP_DIV4 = 25'd4194304;
    localparam logic [RECIP_W-1:0] RECIP_DIV6 = 25'd2796203;
    localparam logic [RECIP_W-1:0] RECIP_DIV9 = 25'd1864136;

    typedef logic [CHAN_W-1:0] t_chan;
    // index 0 red, 1 green, 2 blue
    typedef logic [2:0][CHAN_W-1:0] t_pix;
    // [column c-2..c][row r-2..r][channel]
    typedef logic [2:0][2:0][2:0][CHAN_W-1:0] t_window;
    typedef logic [2:0] t_mask;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        t_mask              rmask;
        t_mask              cmask;
        logic               done;
    } t_job;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WB,
        S_ISSUE
    } t_state;

    function automatic logic [RECIP_W-1:0] recip_of(input t_mask rm, input t_mask cm);
        logic [1:0] nr;
        logic [1:0] nc;
        logic [3:0] n;
        logic [RECIP_W-1:0] m;
        nr = {1'b0, rm[0]} + {1'b0, rm[1]} + {1'b0, rm[2]};
        nc = {1'b0, cm[0]} + {1'b0, cm[1]} + {1'b0, cm[2]};
        n  = {2'b00, nr} * {2'b00, nc};
        unique case (n)
            4'd2:    m = RECIP_DIV2;
            4'd3:    m = RECIP_DIV3;
            4'd4:    m = RECIP_DIV4;
            4'd6:    m = RECIP_DIV6;
            4'd9:    m = RECIP_DIV9;
            default: m = RECIP_DIV1;
        endcase
        return m;
    endfunction

endpackage

// ----- rtl/core/box_blur_3x3_rgb_core.sv -----
// 3x3 box blur of a square rgb image streamed in raster order.
// input channel: i_valid / o_stall, one pixel per beat (16-bit red, green, blue).
// output channel: o_valid / i_stall, one smoothed pixel per beat with its own
// row and column; o_frame_done marks the bottom-right pixel of the frame.
// config channel: i_cfg_valid / o_cfg_ready writes the image side (0 acts as 1,
// values above MAX_SIDE clamp); a write restarts the frame at row 0, column 0.
// each pixel takes a line store read, then a write back and window shift,
// then issues the results it releases (zero to four), one per cycle while
// the output is not stalled; the next pixel is taken in the cycle of the last
// result. the line store read and write back bound how fast pixels are taken.
// after it is issued, a result passes the sum, sum, multiply and output registers.
// while the output beat is stalled the result pipe holds; pixels that release
// no result are still taken, the first one that releases a result is written
// back and then o_stall stays high until the pipe moves again.
// reset returns the side to 1024 (clamped to MAX_SIDE) and row/column to zero;
// the line stores need no clearing, stale entries are never part of a mean.
module box_blur_3x3_rgb_core #(
    parameter int MAX_SIDE = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [bb3_pkg::CHAN_W-1:0]    i_in_red,
    input  logic [bb3_pkg::CHAN_W-1:0]    i_in_green,
    input  logic [bb3_pkg::CHAN_W-1:0]    i_in_blue,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [bb3_pkg::COORD_W-1:0]   o_out_row,
    output logic [bb3_pkg::COORD_W-1:0]   o_out_col,
    output logic [bb3_pkg::CHAN_W-1:0]    o_out_red,
    output logic [bb3_pkg::CHAN_W-1:0]    o_out_green,
    output logic [bb3_pkg::CHAN_W-1:0]    o_out_blue,
    output logic                          o_frame_done,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bb3_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int CW = $clog2(MAX_SIDE);
    localparam int RST_SIDE = (MAX_SIDE < bb3_pkg::CFG_RESET_SIDE) ?
                              MAX_SIDE : bb3_pkg::CFG_RESET_SIDE;

    bb3_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_last, n_last;
    logic [CW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [bb3_pkg::NUM_JOBS-1:0] r_pend, n_pend;
    logic [CW-1:0] r_rq, r_cq;
    bb3_pkg::t_pix r_px;
    bb3_pkg::t_window r_win;

    logic accept, ready, issue, wb, last_job, cfg_we, en;
    logic [1:0] sel;
    logic [bb3_pkg::NUM_JOBS-1:0] new_jobs;
    logic [bb3_pkg::LINE_W-1:0] mem_rd;
    logic [bb3_pkg::LINE_W-1:0] mem_wd;
    logic [31:0] cfg_side;
    logic [CW+bb3_pkg::COORD_W-1:0] row_a_ext, row_b_ext, col_a_ext, col_b_ext;
    bb3_pkg::t_mask rm_a, rm_b, cm_a, cm_b;
    bb3_pkg::t_job job;
    bb3_pkg::t_pix res_pix;

    assign cfg_we = i_cfg_valid && o_cfg_ready;
    assign accept = i_valid && ready;
    assign o_stall = !ready;
    assign last_job = ((r_pend & (r_pend - 1'b1)) == '0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bb3_pkg::S_IDLE: begin
                if (accept) n_state = bb3_pkg::S_WB;
            end
            bb3_pkg::S_WB: begin
                n_state = (r_pend != '0) ? bb3_pkg::S_ISSUE : bb3_pkg::S_IDLE;
            end
            bb3_pkg::S_ISSUE: begin
                if (en && last_job) begin
                    n_state = accept ? bb3_pkg::S_WB : bb3_pkg::S_IDLE;
                end
            end
            default: n_state = bb3_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        ready       = 1'b0;
        issue       = 1'b0;
        wb          = 1'b0;
        o_cfg_ready = 1'b0;
        unique case (r_state)
            bb3_pkg::S_IDLE: begin
                ready       = 1'b1;
                o_cfg_ready = 1'b1;
            end
            bb3_pkg::S_WB: begin
                wb = 1'b1;
            end
            bb3_pkg::S_ISSUE: begin
                issue = en;
                ready = en && last_job;
            end
            default: begin
                ready = 1'b0;
            end
        endcase
    end

    // results released by the pixel at (row, col), in output order
    always_comb begin
        new_jobs[0] = (r_row != '0) && (r_col != '0);
        new_jobs[1] = (r_row != '0) && (r_col == r_last);
        new_jobs[2] = (r_row == r_last) && (r_col != '0);
        new_jobs[3] = (r_row == r_last) && (r_col == r_last);
    end

    always_comb begin
        priority if (r_pend[0]) sel = 2'd0;
        else if (r_pend[1])     sel = 2'd1;
        else if (r_pend[2])     sel = 2'd2;
        else                    sel = 2'd3;
    end

    always_comb begin
        cfg_side = 32'(i_cfg_data);
        if (cfg_side == 32'd0) begin
            n_last = '0;
        end else if (cfg_side > 32'(MAX_SIDE)) begin
            n_last = CW'(MAX_SIDE - 1);
        end else begin
            n_last = CW'(cfg_side - 32'd1);
        end
    end

    always_comb begin
        n_row  = r_row;
        n_col  = r_col;
        n_pend = r_pend;
        if (issue) begin
            n_pend[sel] = 1'b0;
        end
        if (accept) begin
            n_pend = new_jobs;
            if (r_col == r_last) begin
                n_col = '0;
                n_row = (r_row == r_last) ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
        if (cfg_we) begin
            n_row = '0;
            n_col = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bb3_pkg::S_IDLE;
            r_last  <= CW'(RST_SIDE - 1);
            r_row   <= '0;
            r_col   <= '0;
            r_pend  <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_pend  <= n_pend;
            if (cfg_we) begin
                r_last <= n_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rq <= r_row;
            r_cq <= r_col;
            r_px <= {i_in_blue, i_in_green, i_in_red};
        end
        if (wb) begin
            r_win[0]    <= r_win[1];
            r_win[1]    <= r_win[2];
            r_win[2][0] <= bb3_pkg::t_pix'(mem_rd[bb3_pkg::PIX_W +: bb3_pkg::PIX_W]);
            r_win[2][1] <= bb3_pkg::t_pix'(mem_rd[0 +: bb3_pkg::PIX_W]);
            r_win[2][2] <= r_px;
        end
    end

    // upper line takes the old lower line, lower line takes the new pixel
    assign mem_wd = {mem_rd[0 +: bb3_pkg::PIX_W], r_px};

    bb3_line_mem #(
        .DEPTH (MAX_SIDE)
    ) u_line_mem (
        .i_clk   (i_clk),
        .i_re    (accept),
        .i_raddr (r_col),
        .i_we    (wb),
        .i_waddr (r_cq),
        .i_wdata (mem_wd),
        .o_rdata (mem_rd)
    );

    // window rows/columns inside the image for a result one behind or level
    always_comb begin
        rm_a = {1'b1, 1'b1, (r_rq >= CW'(2))};
        rm_b = {1'b1, (r_rq != '0), 1'b0};
        cm_a = {1'b1, 1'b1, (r_cq >= CW'(2))};
        cm_b = {1'b1, (r_cq != '0), 1'b0};
        row_a_ext = {{bb3_pkg::COORD_W{1'b0}}, r_rq - 1'b1};
        row_b_ext = {{bb3_pkg::COORD_W{1'b0}}, r_rq};
        col_a_ext = {{bb3_pkg::COORD_W{1'b0}}, r_cq - 1'b1};
        col_b_ext = {{bb3_pkg::COORD_W{1'b0}}, r_cq};
        job.row   = sel[1] ? row_b_ext[bb3_pkg::COORD_W-1:0]
                           : row_a_ext[bb3_pkg::COORD_W-1:0];
        job.rmask = sel[1] ? rm_b : rm_a;
        job.col   = sel[0] ? col_b_ext[bb3_pkg::COORD_W-1:0]
                           : col_a_ext[bb3_pkg::COORD_W-1:0];
        job.cmask = sel[0] ? cm_b : cm_a;
        job.done  = (sel == 2'd3);
    end

    bb3_mean u_mean (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_issue  (issue),
        .i_job    (job),
        .i_window (r_win),
        .i_stall  (i_stall),
        .o_en     (en),
        .o_valid  (o_valid),
        .o_row    (o_out_row),
        .o_col    (o_out_col),
        .o_pix    (res_pix),
        .o_done   (o_frame_done)
    );

    assign o_out_red   = res_pix[0];
    assign o_out_green = res_pix[1];
    assign o_out_blue  = res_pix[2];

endmodule

// ----- rtl/core/bb3_line_mem.sv -----
module bb3_line_mem #(
    parameter int DEPTH = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_re,
    input  logic [$clog2(DEPTH)-1:0]        i_raddr,
    input  logic                            i_we,
    input  logic [$clog2(DEPTH)-1:0]        i_waddr,
    input  logic [bb3_pkg::LINE_W-1:0]      i_wdata,
    output logic [bb3_pkg::LINE_W-1:0]      o_rdata
);

    logic [bb3_pkg::LINE_W-1:0] r_mem [DEPTH];
    logic [bb3_pkg::LINE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/bb3_mean.sv -----
module bb3_mean (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_issue,
    input  bb3_pkg::t_job               i_job,
    input  bb3_pkg::t_window            i_window,
    input  logic                        i_stall,
    output logic                        o_en,
    output logic                        o_valid,
    output logic [bb3_pkg::COORD_W-1:0] o_row,
    output logic [bb3_pkg::COORD_W-1:0] o_col,
    output bb3_pkg::t_pix               o_pix,
    output logic                        o_done
);

    logic en;

    logic r_v1, r_v2, r_v3, r_vo;
    bb3_pkg::t_job r_job1, r_job2, r_job3, r_jobo;
    logic [2:0][2:0][bb3_pkg::COL_SUM_W-1:0] r_cs1;
    logic [2:0][bb3_pkg::SUM_W-1:0]          r_tot2;
    logic [bb3_pkg::RECIP_W-1:0]             r_recip2;
    logic [2:0][bb3_pkg::PROD_W-1:0]         r_prod3;
    bb3_pkg::t_pix                           r_q;

    logic [2:0][2:0][bb3_pkg::COL_SUM_W-1:0] n_cs1;
    logic [2:0][bb3_pkg::SUM_W-1:0]          n_tot2;
    logic [2:0][bb3_pkg::PROD_W-1:0]         n_prod3;
    bb3_pkg::t_pix                           n_q;

    // whole pipe holds while the output beat is stalled
    assign en = !(r_vo && i_stall);

    // per column sum of the rows in the clipped neighbourhood
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            for (int ch = 0; ch < 3; ch++) begin
                n_cs1[j][ch] = '0;
                for (int i = 0; i < 3; i++) begin
                    if (i_job.rmask[i]) begin
                        n_cs1[j][ch] = n_cs1[j][ch]
                            + bb3_pkg::COL_SUM_W'(i_window[j][i][ch]);
                    end
                end
            end
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            n_tot2[ch] = '0;
            for (int j = 0; j < 3; j++) begin
                if (r_job1.cmask[j]) begin
                    n_tot2[ch] = n_tot2[ch] + bb3_pkg::SUM_W'(r_cs1[j][ch]);
                end
            end
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            n_prod3[ch] = bb3_pkg::PROD_W'(r_tot2[ch]) * bb3_pkg::PROD_W'(r_recip2);
            n_q[ch] = r_prod3[ch][bb3_pkg::RECIP_SH +: bb3_pkg::CHAN_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else if (en) begin
            r_v1 <= i_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_vo <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_job1   <= i_job;
            r_cs1    <= n_cs1;
            r_job2   <= r_job1;
            r_tot2   <= n_tot2;
            r_recip2 <= bb3_pkg::recip_of(r_job1.rmask, r_job1.cmask);
            r_job3   <= r_job2;
            r_prod3  <= n_prod3;
            r_jobo   <= r_job3;
            r_q      <= n_q;
        end
    end

    assign o_en    = en;
    assign o_valid = r_vo;
    assign o_row   = r_jobo.row;
    assign o_col   = r_jobo.col;
    assign o_pix   = r_q;
    assign o_done  = r_jobo.done;

endmodule
